@@ design/ctg_pkg.sv @@
`default_nettype none

package ctg_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_METHOD        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_PRESENT = 2'd2;

    localparam int unsigned CFG_DATA_W = 8;

    // Method codes. Codes above METHOD_MEAN behave as the mean.
    localparam int unsigned METHOD_W = 3;
    localparam logic [METHOD_W-1:0] METHOD_RED   = 3'd0;
    localparam logic [METHOD_W-1:0] METHOD_GREEN = 3'd1;
    localparam logic [METHOD_W-1:0] METHOD_BLUE  = 3'd2;
    localparam logic [METHOD_W-1:0] METHOD_ALPHA = 3'd3;
    localparam logic [METHOD_W-1:0] METHOD_LUMA  = 3'd4;
    localparam logic [METHOD_W-1:0] METHOD_MEAN  = 3'd5;

    localparam logic [METHOD_W-1:0] METHOD_RESET     = METHOD_MEAN;
    localparam logic [7:0]          BACKGROUND_RESET = 8'd0;

    // Luma weights; the weighted sum is shifted right by LUMA_SHIFT.
    localparam logic [14:0] W_RED      = 15'd6969;
    localparam logic [14:0] W_GREEN    = 15'd23434;
    localparam logic [14:0] W_BLUE     = 15'd2365;
    localparam int unsigned LUMA_SHIFT = 15;
    localparam int unsigned LUMA_SUM_W = 23;

    // Divide by 3 for sums below 2048: (x * 683) >> 11.
    localparam logic [9:0]  RECIP3       = 10'd683;
    localparam int unsigned RECIP3_SHIFT = 11;

    // Divide by 255 for sums up to 255 * 255: (x * 32897) >> 23.
    localparam logic [15:0] RECIP255       = 16'd32897;
    localparam int unsigned RECIP255_SHIFT = 23;

    localparam logic [7:0] FULL = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       last_out;
    } result_t;

    // Handoff from the selection stage to the blend stages.
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
        logic [7:0] weight;
        logic       last;
    } ctg_stage_t;

endpackage

`default_nettype wire

@@ design/ctg_blend.sv @@
`default_nettype none

// Blends the selected value with the background gray:
// (weight * value + (255 - weight) * background) / 255.
// A weight of 255 returns the value unchanged.
module ctg_blend
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctg_pkg::ctg_stage_t stage_in,
    input  wire logic [7:0]         background,
    output logic                    result_valid,
    output ctg_pkg::result_t        result
);

    logic        valid_b_reg;
    logic        last_b_reg;
    logic [15:0] fg_prod_reg;
    logic [15:0] bg_prod_reg;
    logic [15:0] fg_prod_next;
    logic [15:0] bg_prod_next;

    logic        valid_c_reg;
    logic        last_c_reg;
    logic [7:0]  gray_c_reg;
    logic [7:0]  gray_c_next;
    logic [16:0] blend_sum;
    logic [32:0] quot_prod;

    always_comb
    begin
        fg_prod_next = 16'(stage_in.weight) * 16'(stage_in.value);
        bg_prod_next = 16'(ctg_pkg::FULL - stage_in.weight) * 16'(background);
    end

    always_comb
    begin
        blend_sum = 17'(fg_prod_reg) + 17'(bg_prod_reg);
        quot_prod = 33'(blend_sum) * 33'(ctg_pkg::RECIP255);
        gray_c_next = quot_prod[ctg_pkg::RECIP255_SHIFT +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= stage_in.valid;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fg_prod_reg <= fg_prod_next;
        bg_prod_reg <= bg_prod_next;
        last_b_reg  <= stage_in.last;
        gray_c_reg  <= gray_c_next;
        last_c_reg  <= last_b_reg;
    end

    assign result_valid    = valid_c_reg;
    assign result.gray     = gray_c_reg;
    assign result.last_out = last_c_reg;

endmodule

`default_nettype wire

@@ design/color_to_gray_with_alpha.sv @@
`default_nettype none

// Pixel to gray converter with optional alpha blend against a background gray.
// Input: a pixel transfer happens at a clock edge where start is high and busy
// is low. busy is always low, so one pixel can be taken every cycle.
// Output: result_valid is high for exactly one cycle with the gray value and
// the copied last flag; the receiver must take it in that cycle.
// Throughput is one pixel per clock. A pixel passes from the start edge to
// result_valid through three pipeline registers: channel selection with the
// luma and mean multipliers, the two blend products, and the divide by 255.
// Configuration is written through wr_en, wr_index and wr_data; index 0 is the
// method, 1 the background gray, 2 the alpha flag. Writes are allowed only
// while no pixel is in flight.
// Reset clears the pipeline valid bits and loads method mean, background 0
// and no alpha. The receiver cannot stall, so there is no backpressure path.
module color_to_gray_with_alpha
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire ctg_pkg::pixel_t                   pixel,
    output logic                                   result_valid,
    output ctg_pkg::result_t                       result,
    input  wire logic                              wr_en,
    input  wire logic [ctg_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [ctg_pkg::CFG_DATA_W-1:0]    wr_data
);

    logic [ctg_pkg::METHOD_W-1:0] method_reg;
    logic [7:0]                   background_reg;
    logic                         alpha_present_reg;

    ctg_pkg::ctg_stage_t stage_a_reg;
    ctg_pkg::ctg_stage_t stage_a_next;

    logic [ctg_pkg::LUMA_SUM_W-1:0] luma_sum;
    logic [7:0]                     luma;
    logic [9:0]                     chan_sum;
    logic [20:0]                    mean_prod;
    logic [7:0]                     mean;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg        <= ctg_pkg::METHOD_RESET;
            background_reg    <= ctg_pkg::BACKGROUND_RESET;
            alpha_present_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ctg_pkg::CFG_METHOD:
                    method_reg <= wr_data[ctg_pkg::METHOD_W-1:0];
                ctg_pkg::CFG_BACKGROUND:
                    background_reg <= wr_data;
                ctg_pkg::CFG_ALPHA_PRESENT:
                    alpha_present_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        luma_sum = ctg_pkg::LUMA_SUM_W'(ctg_pkg::W_RED)   * ctg_pkg::LUMA_SUM_W'(pixel.red)
                 + ctg_pkg::LUMA_SUM_W'(ctg_pkg::W_GREEN) * ctg_pkg::LUMA_SUM_W'(pixel.green)
                 + ctg_pkg::LUMA_SUM_W'(ctg_pkg::W_BLUE)  * ctg_pkg::LUMA_SUM_W'(pixel.blue);
        luma     = luma_sum[ctg_pkg::LUMA_SHIFT +: 8];

        chan_sum  = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);
        mean_prod = 21'(chan_sum) * 21'(ctg_pkg::RECIP3);
        mean      = mean_prod[ctg_pkg::RECIP3_SHIFT +: 8];
    end

    // A weight of full scale makes the blend stages pass the value through,
    // which covers the raw modes and images without alpha.
    always_comb
    begin
        stage_a_next.valid  = start;
        stage_a_next.last   = pixel.last_pixel;
        stage_a_next.weight = ctg_pkg::FULL;
        unique case (method_reg)
            ctg_pkg::METHOD_RED:   stage_a_next.value = pixel.red;
            ctg_pkg::METHOD_GREEN: stage_a_next.value = pixel.green;
            ctg_pkg::METHOD_BLUE:  stage_a_next.value = pixel.blue;
            ctg_pkg::METHOD_ALPHA:
                stage_a_next.value = alpha_present_reg ? pixel.opacity : ctg_pkg::FULL;
            ctg_pkg::METHOD_LUMA:
            begin
                stage_a_next.value = luma;
                if (alpha_present_reg)
                begin
                    stage_a_next.weight = pixel.opacity;
                end
            end
            default:
            begin
                stage_a_next.value = mean;
                if (alpha_present_reg)
                begin
                    stage_a_next.weight = pixel.opacity;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_a_reg <= '0;
        end
        else
        begin
            stage_a_reg <= stage_a_next;
        end
    end

    ctg_blend u_blend
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_in     (stage_a_reg),
        .background   (background_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
